// ----- src/fbfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed block free list allocator package
// Operation and status codes, controller state type and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fbfa_pkg;

  // Operation codes carried by in_operation.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // Status codes carried by out_status.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'd1;

  // Pool capacity in blocks; the index and count fields are sized for it.
  localparam int unsigned MAX_BLOCKS = 1024;

  // Register widths and limits fixed by the field definitions.
  localparam int unsigned POOL_W     = 11;
  localparam int unsigned BYTES_W    = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned OFFSET_W   = 22;
  localparam int unsigned USED_W     = 11;
  localparam int unsigned STAT_W     = 2;
  localparam logic [BYTES_W-1:0] BYTES_MAX    = 13'd4096;
  localparam logic [POOL_W-1:0]  POOL_RESET   = 11'd1024;
  localparam logic [BYTES_W-1:0] BYTES_RESET  = 13'd16;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // latch the accepted input beat
    logic exec;  // decide the operation and update the pool state
    logic fin;   // finish the item and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;  // result register holds a beat that is stalled
  } dp_stat_t;

endpackage

// ----- src/fbfa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle at a shared address, read data registered.
// ----------------------------------------------------------------------------
module fbfa_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/fbfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fixed block free list allocator controller
// Sequences each item through decide and finish steps and drives the input
// handshake.
// ----------------------------------------------------------------------------
module fbfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fbfa_pkg::dp_stat_t dp_stat,
  output fbfa_pkg::dp_cmd_t  dp_cmd
);

  fbfa_pkg::state_t state_r;
  fbfa_pkg::state_t state_nxt;
  logic             fin_go;
  logic             accept;

  // The finish step may complete once the result register is free.
  assign fin_go   = (state_r == fbfa_pkg::ST_FIN) && !dp_stat.out_blocked;
  assign in_stall = !((state_r == fbfa_pkg::ST_IDLE) || fin_go);
  assign accept   = in_valid && !in_stall;

  // Commands to the datapath.
  assign dp_cmd.load = accept;
  assign dp_cmd.exec = (state_r == fbfa_pkg::ST_EXEC);
  assign dp_cmd.fin  = fin_go;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = fbfa_pkg::ST_EXEC;
        end
      end
      fbfa_pkg::ST_EXEC: begin
        state_nxt = fbfa_pkg::ST_FIN;
      end
      fbfa_pkg::ST_FIN: begin
        if (fin_go) begin
          state_nxt = accept ? fbfa_pkg::ST_EXEC : fbfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fbfa_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbfa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/fbfa_dp.sv -----
// ----------------------------------------------------------------------------
// Fixed block free list allocator datapath
// Holds the configuration, the free list head, untouched mark and used count,
// the next-link RAM, the offset multiplier and the result register.
// ----------------------------------------------------------------------------
module fbfa_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbfa_pkg::dp_cmd_t                   dp_cmd,
  output fbfa_pkg::dp_stat_t                  dp_stat,
  input  logic                                cfg_we,
  input  logic [fbfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbfa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [fbfa_pkg::OP_W-1:0]           in_operation,
  input  logic [fbfa_pkg::IDX_W-1:0]          in_free_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fbfa_pkg::STAT_W-1:0]         out_status,
  output logic [fbfa_pkg::IDX_W-1:0]          out_granted_index,
  output logic [fbfa_pkg::OFFSET_W-1:0]       out_granted_offset,
  output logic [fbfa_pkg::USED_W-1:0]         out_blocks_in_use
);

  localparam int unsigned AW = $clog2(fbfa_pkg::MAX_BLOCKS);
  localparam int unsigned LW = $clog2(fbfa_pkg::MAX_BLOCKS + 1);
  localparam int unsigned PW = AW + fbfa_pkg::BYTES_W;
  localparam logic [LW-1:0] HEAD_EMPTY = LW'(fbfa_pkg::MAX_BLOCKS);
  localparam logic [LW-1:0] USED_MAX   = LW'(fbfa_pkg::MAX_BLOCKS);

  // Configuration registers.
  logic [fbfa_pkg::POOL_W-1:0]  pool_r;
  logic [fbfa_pkg::BYTES_W-1:0] bytes_r;

  // Latched input beat.
  logic [fbfa_pkg::OP_W-1:0]  op_r;
  logic [fbfa_pkg::IDX_W-1:0] fidx_r;

  // Pool state.
  logic [LW-1:0] head_r;
  logic [LW-1:0] untouched_r;
  logic [LW-1:0] used_r;

  // Per-item results of the decide step.
  logic [AW-1:0]               blk_r;
  logic                        pop_r;
  logic [fbfa_pkg::STAT_W-1:0] res_status_r;

  // Result register.
  logic                          out_valid_r;
  logic [fbfa_pkg::STAT_W-1:0]   out_status_r;
  logic [fbfa_pkg::IDX_W-1:0]    out_index_r;
  logic [fbfa_pkg::OFFSET_W-1:0] out_offset_r;
  logic [fbfa_pkg::USED_W-1:0]   out_used_r;

  // Effective register values and decisions.
  logic [31:0]                  pool_w;
  logic [31:0]                  pool_eff;
  logic [fbfa_pkg::BYTES_W-1:0] bytes_eff;
  logic [31:0]                  fidx_w;
  logic                         list_nonempty;
  logic                         fresh_ok;
  logic                         free_ok;
  logic                         do_pop;
  logic                         do_push;
  logic [LW-1:0]                link_rdata;
  logic [AW-1:0]                ram_addr;
  logic [PW-1:0]                prod;

  // Clamp the registers into their usable ranges.
  assign pool_w   = 32'(pool_r);
  assign pool_eff = (pool_w == 32'd0) ? 32'd1 :
                    (pool_w > 32'(fbfa_pkg::MAX_BLOCKS)) ? 32'(fbfa_pkg::MAX_BLOCKS) : pool_w;
  assign bytes_eff = (bytes_r == '0) ? fbfa_pkg::BYTES_W'(1) :
                     (bytes_r > fbfa_pkg::BYTES_MAX) ? fbfa_pkg::BYTES_MAX : bytes_r;

  // Allocation and free decisions.
  assign fidx_w        = 32'(fidx_r);
  assign list_nonempty = (head_r != HEAD_EMPTY);
  assign fresh_ok      = (32'(untouched_r) < pool_eff);
  assign free_ok       = (fidx_w < pool_eff);
  assign do_pop  = dp_cmd.exec && (op_r == fbfa_pkg::OP_ALLOC) && list_nonempty;
  assign do_push = dp_cmd.exec && (op_r == fbfa_pkg::OP_FREE) && free_ok;
  assign ram_addr = do_pop ? head_r[AW-1:0] : fidx_w[AW-1:0];

  // Next-link storage: a push writes the old head, a pop reads the next link.
  fbfa_ram #(
    .WIDTH (LW),
    .DEPTH (fbfa_pkg::MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (do_push),
    .re    (do_pop),
    .addr  (ram_addr),
    .wdata (head_r),
    .rdata (link_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r  <= fbfa_pkg::POOL_RESET;
      bytes_r <= fbfa_pkg::BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbfa_pkg::CFG_POOL_BLOCKS: pool_r  <= fbfa_pkg::POOL_W'(cfg_wdata);
        fbfa_pkg::CFG_BLOCK_BYTES: bytes_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op_r   <= in_operation;
      fidx_r <= in_free_index;
    end
  end

  // Pool state update: decide step, plus head reload from the link RAM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= HEAD_EMPTY;
      untouched_r <= '0;
      used_r      <= '0;
      pop_r       <= 1'b0;
    end else begin
      if (dp_cmd.fin && pop_r) begin
        head_r <= link_rdata;
      end
      if (dp_cmd.exec) begin
        pop_r <= 1'b0;
        unique case (op_r)
          fbfa_pkg::OP_ALLOC: begin
            if (list_nonempty) begin
              pop_r <= 1'b1;
            end else if (fresh_ok) begin
              untouched_r <= untouched_r + LW'(1);
            end
            if ((list_nonempty || fresh_ok) && (used_r < USED_MAX)) begin
              used_r <= used_r + LW'(1);
            end
          end
          fbfa_pkg::OP_FREE: begin
            if (free_ok) begin
              head_r <= LW'(fidx_w);
              if (used_r != '0) begin
                used_r <= used_r - LW'(1);
              end
            end
          end
          fbfa_pkg::OP_RESET: begin
            head_r      <= HEAD_EMPTY;
            untouched_r <= '0;
            used_r      <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Per-item block index and status from the decide step.
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      blk_r        <= '0;
      res_status_r <= fbfa_pkg::STAT_OK;
      unique case (op_r)
        fbfa_pkg::OP_ALLOC: begin
          if (list_nonempty) begin
            blk_r <= head_r[AW-1:0];
          end else if (fresh_ok) begin
            blk_r <= untouched_r[AW-1:0];
          end else begin
            res_status_r <= fbfa_pkg::STAT_EXHAUSTED;
          end
        end
        fbfa_pkg::OP_FREE: begin
          if (!free_ok) begin
            res_status_r <= fbfa_pkg::STAT_BAD_INDEX;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Byte offset of the granted block.
  assign prod = PW'(blk_r) * PW'(bytes_eff);

  // Result register and its handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.fin) begin
      out_status_r <= res_status_r;
      out_index_r  <= fbfa_pkg::IDX_W'(blk_r);
      out_offset_r <= fbfa_pkg::OFFSET_W'(prod);
      out_used_r   <= fbfa_pkg::USED_W'(used_r);
    end
  end

  assign dp_stat.out_blocked = out_valid_r && out_stall;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_index   = out_index_r;
  assign out_granted_offset  = out_offset_r;
  assign out_blocks_in_use   = out_used_r;

endmodule

// ----- src/fixed_block_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Fixed block free list allocator
// Pool of equal-size blocks handed out from a LIFO free list.
// ----------------------------------------------------------------------------
// Each accepted beat (allocate, free or pool reset) yields exactly one result
// beat, loaded into the result register at the end of its finish step. A new
// beat is accepted in the same cycle that the previous result is loaded into
// the output register, and never while the previous beat is in its decide
// step, because the registered read of the next-link RAM must return the
// following list head before the next allocate can pop. The result register
// holds a stalled beat, and the block keeps working up to that register. The
// link RAM needs no clearing pass after reset: a link is read only for a
// block that was freed, and a free always writes it. Configuration may be
// written only while no item is in flight.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fbfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbfa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fbfa_pkg::OP_W-1:0]         in_operation,
  input  logic [fbfa_pkg::IDX_W-1:0]        in_free_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fbfa_pkg::STAT_W-1:0]       out_status,
  output logic [fbfa_pkg::IDX_W-1:0]        out_granted_index,
  output logic [fbfa_pkg::OFFSET_W-1:0]     out_granted_offset,
  output logic [fbfa_pkg::USED_W-1:0]       out_blocks_in_use
);

  fbfa_pkg::dp_cmd_t  dp_cmd;
  fbfa_pkg::dp_stat_t dp_stat;

  // Controller.
  fbfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  // Datapath.
  fbfa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .dp_cmd             (dp_cmd),
    .dp_stat            (dp_stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_operation),
    .in_free_index      (in_free_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_index  (out_granted_index),
    .out_granted_offset (out_granted_offset),
    .out_blocks_in_use  (out_blocks_in_use)
  );

  // An accepted beat is never followed by another in the next cycle.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted in two consecutive cycles");

  // A new result appears only from a finish step.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(dp_cmd.fin))
    else $error("result valid without a finish step");

  // A finish step never overwrites a stalled result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.fin |-> !(out_valid && out_stall))
    else $error("finish step while result stalled");

  // An exhausted pool grants nothing.
  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == fbfa_pkg::STAT_EXHAUSTED)) |->
      ((out_granted_index == '0) && (out_granted_offset == '0)))
    else $error("grant fields nonzero on exhausted pool");

endmodule

// ----- sim/allocator_checker.sv -----
// ----------------------------------------------------------------------------
// Block pool allocator checker
// Watches the configuration port and both beat channels of the allocator,
// keeps its own copy of the free list, and compares every result beat
// field by field with the oldest predicted grant.
// ----------------------------------------------------------------------------
module allocator_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fbfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [fbfa_pkg::OP_W-1:0]       in_operation,
  input  logic [fbfa_pkg::IDX_W-1:0]      in_free_index,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [fbfa_pkg::STAT_W-1:0]     out_status,
  input  logic [fbfa_pkg::IDX_W-1:0]      out_granted_index,
  input  logic [fbfa_pkg::OFFSET_W-1:0]   out_granted_offset,
  input  logic [fbfa_pkg::USED_W-1:0]     out_blocks_in_use,
  output int                              fail_count,
  output int                              pending_beats
);

  typedef struct packed {
    logic [fbfa_pkg::STAT_W-1:0]   status;
    logic [fbfa_pkg::IDX_W-1:0]    index;
    logic [fbfa_pkg::OFFSET_W-1:0] offset;
    logic [fbfa_pkg::USED_W-1:0]   in_use;
  } grant_t;

  // Shadow pool state and configuration.
  logic [fbfa_pkg::POOL_W-1:0]  link_mem [0:fbfa_pkg::MAX_BLOCKS-1];
  logic [fbfa_pkg::POOL_W-1:0]  head;
  logic [fbfa_pkg::POOL_W-1:0]  mark;
  logic [fbfa_pkg::POOL_W-1:0]  in_use;
  logic [fbfa_pkg::POOL_W-1:0]  pool_reg;
  logic [fbfa_pkg::BYTES_W-1:0] bytes_reg;
  grant_t                       grant_q[$];

  // Registers are clamped into their legal ranges where they are used.
  function automatic logic [fbfa_pkg::POOL_W-1:0] pool_size();
    if (pool_reg == '0) return fbfa_pkg::POOL_W'(1);
    if (pool_reg > fbfa_pkg::MAX_BLOCKS) return fbfa_pkg::POOL_W'(fbfa_pkg::MAX_BLOCKS);
    return pool_reg;
  endfunction

  function automatic logic [fbfa_pkg::BYTES_W-1:0] block_size();
    if (bytes_reg == '0) return fbfa_pkg::BYTES_W'(1);
    if (bytes_reg > fbfa_pkg::BYTES_MAX) return fbfa_pkg::BYTES_MAX;
    return bytes_reg;
  endfunction

  // Empty the list and mark every block as never handed out.
  task automatic clear_pool();
    head   = fbfa_pkg::POOL_W'(fbfa_pkg::MAX_BLOCKS);
    mark   = '0;
    in_use = '0;
  endtask

  // Apply one accepted request to the shadow pool and queue its grant.
  task automatic apply_pool_op(input logic [fbfa_pkg::OP_W-1:0] op,
                               input logic [fbfa_pkg::IDX_W-1:0] fidx);
    grant_t                      g;
    logic [fbfa_pkg::POOL_W-1:0] blk;
    logic [31:0]                 prod;
    logic                        ok;
    g  = '0;
    ok = 1'b1;
    blk = '0;
    case (op)
      fbfa_pkg::OP_ALLOC: begin
        // Freed blocks go out first, most recent on top.
        if (head < fbfa_pkg::MAX_BLOCKS) begin
          blk  = head;
          head = link_mem[head];
        end else if (mark < pool_size()) begin
          blk  = mark;
          mark = mark + 1'b1;
        end else begin
          ok = 1'b0;
        end
        if (ok) begin
          if (in_use < fbfa_pkg::MAX_BLOCKS) in_use = in_use + 1'b1;
          prod     = 32'(blk) * 32'(block_size());
          g.index  = blk[fbfa_pkg::IDX_W-1:0];
          g.offset = prod[fbfa_pkg::OFFSET_W-1:0];
        end else begin
          g.status = fbfa_pkg::STAT_EXHAUSTED;
        end
      end
      fbfa_pkg::OP_FREE: begin
        // A free is pushed even when the block was not in use.
        if (fidx >= pool_size()) begin
          g.status = fbfa_pkg::STAT_BAD_INDEX;
        end else begin
          link_mem[fidx] = head;
          head = fbfa_pkg::POOL_W'(fidx);
          if (in_use != '0) in_use = in_use - 1'b1;
        end
      end
      fbfa_pkg::OP_RESET: clear_pool();
      default: ;
    endcase
    g.in_use = in_use;
    grant_q.push_back(g);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    for (int i = 0; i < fbfa_pkg::MAX_BLOCKS; i++) link_mem[i] = '0;
  end

  // Track configuration writes and request beats, then check result beats.
  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      clear_pool();
      pool_reg   = fbfa_pkg::POOL_RESET;
      bytes_reg  = fbfa_pkg::BYTES_RESET;
      fail_count = 0;
      grant_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == fbfa_pkg::CFG_POOL_BLOCKS) begin
          pool_reg = cfg_wdata[fbfa_pkg::POOL_W-1:0];
        end else begin
          bytes_reg = cfg_wdata[fbfa_pkg::BYTES_W-1:0];
        end
      end
      if (in_valid && !in_stall) apply_pool_op(in_operation, in_free_index);
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $display("%0t: result beat with no request waiting, expected none, actual status %0d",
                   $time, out_status);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("granted_index", 32'(want.index), 32'(out_granted_index));
          check_field("granted_offset", 32'(want.offset), 32'(out_granted_offset));
          check_field("blocks_in_use", 32'(want.in_use), 32'(out_blocks_in_use));
        end
      end
    end
    pending_beats = grant_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Block pool allocator testbench
// Drives allocate, free and pool reset beats through several pool and block
// size settings, with random gaps and output stalls; the checker beside the
// block predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

  // Operation code that the block must answer without any effect.
  localparam logic [fbfa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [fbfa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fbfa_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_stall;
  logic [fbfa_pkg::OP_W-1:0]       in_operation;
  logic [fbfa_pkg::IDX_W-1:0]      in_free_index;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [fbfa_pkg::STAT_W-1:0]     out_status;
  logic [fbfa_pkg::IDX_W-1:0]      out_granted_index;
  logic [fbfa_pkg::OFFSET_W-1:0]   out_granted_offset;
  logic [fbfa_pkg::USED_W-1:0]     out_blocks_in_use;
  int                              fail_count;
  int                              pending_beats;
  logic                            quiet;
  int unsigned                     pool_size;

  fixed_block_free_list_allocator_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_free_index      (in_free_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_index  (out_granted_index),
    .out_granted_offset (out_granted_offset),
    .out_blocks_in_use  (out_blocks_in_use)
  );

  allocator_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_free_index      (in_free_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_index  (out_granted_index),
    .out_granted_offset (out_granted_offset),
    .out_blocks_in_use  (out_blocks_in_use),
    .fail_count         (fail_count),
    .pending_beats      (pending_beats)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random except during the quiet stretch.
  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 19);
  end

  // Present one request beat after a random gap and hold it until accepted.
  task automatic send_beat(input logic [fbfa_pkg::OP_W-1:0] op,
                           input logic [fbfa_pkg::IDX_W-1:0] idx);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_free_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every predicted result beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
  endtask

  // Registers are only written with nothing in flight.
  task automatic write_reg(input logic [fbfa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbfa_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pool(input logic [fbfa_pkg::CFG_DATA_W-1:0] data);
    write_reg(fbfa_pkg::CFG_POOL_BLOCKS, data);
    if (data[fbfa_pkg::POOL_W-1:0] == '0) pool_size = 1;
    else if (data[fbfa_pkg::POOL_W-1:0] > fbfa_pkg::MAX_BLOCKS) pool_size = fbfa_pkg::MAX_BLOCKS;
    else pool_size = 32'(data[fbfa_pkg::POOL_W-1:0]);
  endtask

  // Random mix: mostly allocates and in-range frees, with some bad indexes,
  // pool resets, the unused code and an occasional full drain.
  task automatic run_mix(input int n);
    int unsigned r;
    logic [fbfa_pkg::IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        send_beat(fbfa_pkg::OP_ALLOC, fbfa_pkg::IDX_W'($urandom));
      end else if (r < 88) begin
        idx = ($urandom_range(9) < 8) ? fbfa_pkg::IDX_W'($urandom_range(pool_size - 1))
                                      : fbfa_pkg::IDX_W'($urandom_range(1023));
        send_beat(fbfa_pkg::OP_FREE, idx);
      end else if (r < 95) begin
        send_beat(fbfa_pkg::OP_RESET, fbfa_pkg::IDX_W'($urandom));
      end else begin
        send_beat(OP_UNUSED, fbfa_pkg::IDX_W'($urandom));
      end
      if ($urandom_range(63) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = fbfa_pkg::CFG_POOL_BLOCKS;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_operation  = fbfa_pkg::OP_ALLOC;
    in_free_index = '0;
    quiet         = 1'b0;
    pool_size     = fbfa_pkg::MAX_BLOCKS;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Three large blocks: exhaustion, reuse order, bad frees, double frees.
    set_pool(13'd3);
    write_reg(fbfa_pkg::CFG_BLOCK_BYTES, 13'd4096);
    repeat (4) send_beat(fbfa_pkg::OP_ALLOC, 10'h3ff);
    send_beat(fbfa_pkg::OP_FREE, 10'd1);
    send_beat(fbfa_pkg::OP_FREE, 10'd2);
    repeat (3) send_beat(fbfa_pkg::OP_ALLOC, 10'd0);
    send_beat(fbfa_pkg::OP_FREE, 10'd3);
    send_beat(fbfa_pkg::OP_FREE, 10'h3ff);
    send_beat(OP_UNUSED, 10'd0);
    send_beat(fbfa_pkg::OP_RESET, 10'd0);
    send_beat(fbfa_pkg::OP_FREE, 10'd0);
    send_beat(fbfa_pkg::OP_FREE, 10'd0);
    repeat (6) send_beat(fbfa_pkg::OP_ALLOC, 10'd0);

    // Zero register values clamp to a single one-byte block.
    set_pool(13'd0);
    write_reg(fbfa_pkg::CFG_BLOCK_BYTES, 13'd0);
    run_mix(40);

    // Over-range registers clamp to the full pool of largest blocks. Frees
    // with nothing in use leave the count at zero and loop one block onto
    // the list, so it is handed out again and again. After a pool reset a
    // long run of fresh blocks raises the count, and freeing and taking
    // back the top block gives the largest offset.
    set_pool(13'h1fff);
    write_reg(fbfa_pkg::CFG_BLOCK_BYTES, 13'h1fff);
    quiet = 1'b1;
    send_beat(fbfa_pkg::OP_RESET, 10'd0);
    repeat (3) send_beat(fbfa_pkg::OP_FREE, 10'd7);
    repeat (4) send_beat(fbfa_pkg::OP_ALLOC, fbfa_pkg::IDX_W'($urandom));
    send_beat(fbfa_pkg::OP_RESET, 10'd0);
    repeat (430) send_beat(fbfa_pkg::OP_ALLOC, fbfa_pkg::IDX_W'($urandom));
    send_beat(fbfa_pkg::OP_FREE, 10'd1023);
    send_beat(fbfa_pkg::OP_ALLOC, 10'd0);
    send_beat(fbfa_pkg::OP_FREE, 10'd1000);
    send_beat(fbfa_pkg::OP_FREE, 10'd900);
    quiet = 1'b0;

    // Shrunk pool still hands out the high blocks left on the list.
    set_pool(13'd4);
    write_reg(fbfa_pkg::CFG_BLOCK_BYTES, 13'd1);
    run_mix(100);

    // Values out of reset.
    set_pool(13'd1024);
    write_reg(fbfa_pkg::CFG_BLOCK_BYTES, 13'd16);
    run_mix(100);

    // Small random pools with random upper data bits and block sizes.
    for (int k = 0; k < 4; k++) begin
      set_pool({2'($urandom), 11'($urandom_range(1, 48))});
      write_reg(fbfa_pkg::CFG_BLOCK_BYTES, 13'($urandom_range(1, 8191)));
      run_mix(60);
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/fbfa_pkg.sv
src/fbfa_ram.sv
src/fbfa_ctrl.sv
src/fbfa_dp.sv
src/fixed_block_free_list_allocator_top.sv
sim/allocator_checker.sv
sim/testbench.sv
